[rtl/core/assert_macros.svh]
// Assertion helpers used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define IRPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Condition that must never be true at a clock edge.
`define IRPD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

[rtl/core/irpd_pkg.sv]
package irpd_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned KeyW      = 8;
  localparam int unsigned CountW    = 6;
  localparam int unsigned CfgIdxW   = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLeaderLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLeaderHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegZeroLow    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegZeroHigh   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOneLow     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOneHigh    = 3'd5;

  // Reset values of the window limits (microseconds)
  localparam logic [IntervalW-1:0] LeaderLowRst  = 16'd12200;
  localparam logic [IntervalW-1:0] LeaderHighRst = 16'd13000;
  localparam logic [IntervalW-1:0] ZeroLowRst    = 16'd950;
  localparam logic [IntervalW-1:0] ZeroHighRst   = 16'd1120;
  localparam logic [IntervalW-1:0] OneLowRst     = 16'd1920;
  localparam logic [IntervalW-1:0] OneHighRst    = 16'd2120;

  localparam logic [CountW-1:0] FrameEdges  = 6'd34;
  localparam logic [CountW-1:0] LastBitEdge = 6'd33;

  typedef struct packed {
    logic [IntervalW-1:0] leader_low;
    logic [IntervalW-1:0] leader_high;
    logic [IntervalW-1:0] zero_low;
    logic [IntervalW-1:0] zero_high;
    logic [IntervalW-1:0] one_low;
    logic [IntervalW-1:0] one_high;
  } cfg_t;

  typedef struct packed {
    logic leader;
    logic zero;
    logic one;
  } class_t;

  typedef struct packed {
    logic              emit;
    logic [CountW-1:0] edge_count;
  } frame_st_t;

  // Strict window test: lo < v < hi
  function automatic logic in_window(logic [IntervalW-1:0] v,
                                     logic [IntervalW-1:0] lo,
                                     logic [IntervalW-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

[rtl/core/irpd_cfg_regs.sv]
module irpd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [irpd_pkg::IntervalW-1:0] cfg_data_i,
  output irpd_pkg::cfg_t                cfg_o
);

  irpd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        irpd_pkg::RegLeaderLow:  cfg_d.leader_low  = cfg_data_i;
        irpd_pkg::RegLeaderHigh: cfg_d.leader_high = cfg_data_i;
        irpd_pkg::RegZeroLow:    cfg_d.zero_low    = cfg_data_i;
        irpd_pkg::RegZeroHigh:   cfg_d.zero_high   = cfg_data_i;
        irpd_pkg::RegOneLow:     cfg_d.one_low     = cfg_data_i;
        irpd_pkg::RegOneHigh:    cfg_d.one_high    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low  <= irpd_pkg::LeaderLowRst;
      cfg_q.leader_high <= irpd_pkg::LeaderHighRst;
      cfg_q.zero_low    <= irpd_pkg::ZeroLowRst;
      cfg_q.zero_high   <= irpd_pkg::ZeroHighRst;
      cfg_q.one_low     <= irpd_pkg::OneLowRst;
      cfg_q.one_high    <= irpd_pkg::OneHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/irpd_classify.sv]
module irpd_classify (
  input  logic [irpd_pkg::IntervalW-1:0] interval_i,
  input  irpd_pkg::cfg_t                 cfg_i,
  output irpd_pkg::class_t               class_o
);

  logic is_zero;

  assign is_zero = irpd_pkg::in_window(interval_i, cfg_i.zero_low, cfg_i.zero_high);

  // Zero window wins over one window when they overlap
  assign class_o.leader = irpd_pkg::in_window(interval_i, cfg_i.leader_low,
                                              cfg_i.leader_high);
  assign class_o.zero   = is_zero;
  assign class_o.one    = !is_zero &&
                          irpd_pkg::in_window(interval_i, cfg_i.one_low, cfg_i.one_high);

endmodule

[rtl/core/irpd_frame.sv]
module irpd_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        proc_i,
  input  irpd_pkg::class_t            class_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [irpd_pkg::FrameW-1:0] frame_code_o,
  output logic [irpd_pkg::KeyW-1:0]   key_code_o,
  output logic                        check_ok_o,
  output irpd_pkg::frame_st_t         status_o
);

  logic [irpd_pkg::CountW-1:0] edge_count_q, edge_count_d;
  logic [irpd_pkg::FrameW-1:0] shift_word_q, shift_word_d;
  logic [irpd_pkg::CountW-1:0] cnt_lead, cnt_next;
  logic [irpd_pkg::FrameW-1:0] sw_lead, sw_next;
  logic                        emit;
  logic [irpd_pkg::KeyW-1:0]   key_next;
  logic                        out_valid_q, out_valid_d;
  logic [irpd_pkg::FrameW-1:0] frame_q;
  logic [irpd_pkg::KeyW-1:0]   key_q;
  logic                        ok_q;

  always_comb begin
    cnt_lead = edge_count_q;
    sw_lead  = shift_word_q;
    if (class_i.leader) begin
      cnt_lead = 6'd1;
      sw_lead  = '0;
    end
    sw_next = sw_lead;
    if (cnt_lead < irpd_pkg::FrameEdges) begin
      if (class_i.one) begin
        sw_next[irpd_pkg::FrameW-1] = 1'b1;
      end
      // last bit edge keeps the word in place
      if ((class_i.zero || class_i.one) && (cnt_lead < irpd_pkg::LastBitEdge)) begin
        sw_next = {1'b0, sw_next[irpd_pkg::FrameW-1:1]};
      end
    end
    cnt_next = cnt_lead + 6'd1;
    emit     = (cnt_next == irpd_pkg::FrameEdges);
    key_next = sw_next[23:16];
  end

  always_comb begin
    edge_count_d = edge_count_q;
    shift_word_d = shift_word_q;
    if (proc_i) begin
      edge_count_d = emit ? '0 : cnt_next;
      shift_word_d = sw_next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc_i && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
      shift_word_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      edge_count_q <= edge_count_d;
      shift_word_q <= shift_word_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_i && emit) begin
      frame_q <= sw_next;
      key_q   <= key_next;
      ok_q    <= (key_next == ~sw_next[31:24]);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_code_o        = frame_q;
  assign key_code_o          = key_q;
  assign check_ok_o          = ok_q;
  assign status_o.emit       = emit;
  assign status_o.edge_count = edge_count_q;

endmodule

[rtl/core/ir_pulse_distance_frame_decoder_top.sv]
// IR pulse-distance frame decoder, top level.
// An accepted edge is held in the input register; a frame it completes is then registered.
// Throughput: one edge transaction per cycle; only a stalled, full result register
//   (one pending frame) holds back the input stage.
// Reset: rst_ni is asynchronous, active low; it restores the default window limits,
//   clears the edge count and shift word and drops both valid flags.
`include "assert_macros.svh"

module ir_pulse_distance_frame_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [irpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [irpd_pkg::IntervalW-1:0] cfg_data_i,
  // edge interval channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [irpd_pkg::IntervalW-1:0] edge_interval_i,
  // frame result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [irpd_pkg::FrameW-1:0]    frame_code_o,
  output logic [irpd_pkg::KeyW-1:0]      key_code_o,
  output logic                           check_ok_o
);

  irpd_pkg::cfg_t                 cfg;
  irpd_pkg::class_t               cls;
  irpd_pkg::frame_st_t            frame_st;
  logic                           s1_valid_q, s1_valid_d;
  logic [irpd_pkg::IntervalW-1:0] s1_interval_q;
  logic                           in_accept;
  logic                           proc;

  // Window limits
  irpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input stage. The registered interval is consumed in the next cycle unless
  // the result register holds a frame that the sink is stalling.
  assign proc       = s1_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = s1_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_interval_q <= edge_interval_i;
    end
  end

  // Window compares: leader, zero bit, one bit
  irpd_classify u_classify (
    .interval_i (s1_interval_q),
    .cfg_i      (cfg),
    .class_o    (cls)
  );

  // Edge counter, shift word and result register
  irpd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .proc_i       (proc),
    .class_i      (cls),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .frame_code_o (frame_code_o),
    .key_code_o   (key_code_o),
    .check_ok_o   (check_ok_o),
    .status_o     (frame_st)
  );

  // A completed frame always resets the count and shows up on the output
  `IRPD_ASSERT(a_emit_clears_count, (proc && frame_st.emit) |=> (frame_st.edge_count == '0))
  `IRPD_ASSERT(a_emit_shows_result, (proc && frame_st.emit) |=> out_valid_o)
  // The count never reaches the frame length between transactions
  `IRPD_ASSERT_NEVER(a_count_range, frame_st.edge_count >= irpd_pkg::FrameEdges)
  // Check flag agrees with the presented frame
  `IRPD_ASSERT(a_check_flag, out_valid_o |->
    ((key_code_o == frame_code_o[23:16]) &&
     (check_ok_o == (frame_code_o[23:16] == ~frame_code_o[31:24]))))

endmodule

[verif/ir_pulse_distance_frame_decoder_top_tb.sv]
`timescale 1ns / 100ps

module ir_pulse_distance_frame_decoder_top_tb;
  import irpd_pkg::*;

  // Spare register slots: a write there must leave every window untouched.
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  // The completing edge passes the input register and then the result register. Settle
  // past both before touching the registers or ending the run.
  localparam int SettleCycles = 4;
  localparam int CycleLimit   = 400000;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [KeyW-1:0]   key;
    logic              ok;
  } frame_result_t;

  // One table row: an interval repeated reps times. Where typed is set, the last
  // repetition completes a frame whose fields are written out in the row.
  typedef struct {
    logic [IntervalW-1:0] interval;
    int                   reps;
    bit                   typed;
    frame_result_t        want;
  } edge_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i     = '0;
  logic [IntervalW-1:0] cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [IntervalW-1:0] edge_interval_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [FrameW-1:0]    frame_code_o;
  logic [KeyW-1:0]      key_code_o;
  logic                 check_ok_o;

  ir_pulse_distance_frame_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .edge_interval_i(edge_interval_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_code_o   (frame_code_o),
    .key_code_o     (key_code_o),
    .check_ok_o     (check_ok_o)
  );

  // ---------------------------------------------------------------------------
  // Decoder mirror: window limits, edge counter and shift word as the block
  // should hold them after every accepted edge.
  // ---------------------------------------------------------------------------
  cfg_t              win = '{LeaderLowRst, LeaderHighRst, ZeroLowRst, ZeroHighRst,
                             OneLowRst, OneHighRst};
  logic [CountW-1:0] edges_in_frame = '0;
  logic [FrameW-1:0] rx_word        = '0;

  frame_result_t frames_due[$];   // decoded frames still owed by the block
  int edges_sent    = 0;
  int frames_seen   = 0;
  int mismatches    = 0;
  int settings_used = 1;          // reset limits count as the first setting
  bit bursts_on     = 1'b1;       // random idling on both channels

  // Advance the mirror by one edge; returns 1 when that edge closes a frame.
  function automatic bit decode_edge(input logic [IntervalW-1:0] t,
                                     output frame_result_t res);
    bit is_zero;
    bit is_one;
    res = '0;
    // Leader restarts the frame, but the same interval still gets the bit tests.
    if (t > win.leader_low && t < win.leader_high) begin
      edges_in_frame = 6'd1;
      rx_word        = '0;
    end
    if (edges_in_frame < FrameEdges) begin
      is_zero = (t > win.zero_low) && (t < win.zero_high);
      is_one  = !is_zero && (t > win.one_low) && (t < win.one_high);
      if (is_one) rx_word[FrameW-1] = 1'b1;
      // LSB first: shift toward bit 0, except on the final bit edge
      if ((is_zero || is_one) && edges_in_frame < LastBitEdge) rx_word = rx_word >> 1;
    end
    edges_in_frame = edges_in_frame + 6'd1;   // wraps in 6 bits
    if (edges_in_frame != FrameEdges) return 1'b0;
    edges_in_frame = '0;                      // shift word is kept until a leader
    res.frame = rx_word;
    res.key   = rx_word[23:16];
    res.ok    = (rx_word[23:16] == ~rx_word[31:24]);
    return 1'b1;
  endfunction

  // Random interval strictly inside (lo, hi); any interval if the window is empty.
  function automatic logic [IntervalW-1:0] pick_between(input logic [IntervalW-1:0] lo,
                                                        input logic [IntervalW-1:0] hi);
    if (int'(hi) > int'(lo) + 1)
      return IntervalW'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return IntervalW'($urandom_range(0, 65535));
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, result stall and run-length watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result-side back pressure: stall bursts of random length.
  always @(posedge clk_i) begin : stall_gen
    static int stall_left = 0;
    if (stall_left == 0 && bursts_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 9);
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d frames still owed", cycles, frames_due.size());
    $display("ir_pulse_distance_frame_decoder_top_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transaction on the frame channel is matched against
  // the oldest owed frame, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : frame_check
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        flag_mismatch("frame with nothing owed", frame_code_o, '0);
      end else begin
        want = frames_due.pop_front();
        if (frame_code_o !== want.frame) flag_mismatch("frame_code", frame_code_o, want.frame);
        if (key_code_o !== want.key)
          flag_mismatch("key_code", 32'(key_code_o), 32'(want.key));
        if (check_ok_o !== want.ok)
          flag_mismatch("check_ok", 32'(check_ok_o), 32'(want.ok));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One edge transaction, optionally preceded by an idle burst. A typed row
  // supplies the frame it owes; otherwise the mirror's frame is owed.
  task automatic send_edge(input logic [IntervalW-1:0] v, input bit typed,
                           input frame_result_t typed_want);
    frame_result_t pred;
    bit closes;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    edge_interval_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    edges_sent++;
    closes = decode_edge(v, pred);
    if (closes) frames_due.push_back(typed ? typed_want : pred);
    else if (typed) flag_mismatch("table row owes a frame the mirror did not close",
                                  '0, typed_want.frame);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [IntervalW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegLeaderLow:  win.leader_low  = val;
      RegLeaderHigh: win.leader_high = val;
      RegZeroLow:    win.zero_low    = val;
      RegZeroHigh:   win.zero_high   = val;
      RegOneLow:     win.one_low     = val;
      RegOneHigh:    win.one_high    = val;
      default: ;
    endcase
  endtask

  // Only called with the block drained, so no edge sees a half-written set.
  task automatic program_windows(input cfg_t w);
    cfg_write(RegLeaderLow,  w.leader_low);
    cfg_write(RegLeaderHigh, w.leader_high);
    cfg_write(RegZeroLow,    w.zero_low);
    cfg_write(RegZeroHigh,   w.zero_high);
    cfg_write(RegOneLow,     w.one_low);
    cfg_write(RegOneHigh,    w.one_high);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Let owed frames arrive, then give edges that close nothing time to retire.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leader plus 32 bit intervals in the current windows. Half the frames carry
  // a valid inverted command byte. Some edges are replaced by noise and some
  // frames are cut short.
  task automatic send_frame();
    logic [FrameW-1:0]    payload;
    logic [IntervalW-1:0] v;
    payload = $urandom;
    if ($urandom_range(0, 1)) payload[31:24] = ~payload[23:16];
    send_edge(pick_between(win.leader_low, win.leader_high), 1'b0, '0);
    for (int i = 0; i < FrameW; i++) begin
      if ($urandom_range(0, 59) == 0) return;
      v = payload[i] ? pick_between(win.one_low, win.one_high)
                     : pick_between(win.zero_low, win.zero_high);
      if ($urandom_range(0, 39) == 0) v = IntervalW'($urandom_range(0, 65535));
      send_edge(v, 1'b0, '0);
    end
  endtask

  // Mostly frames, some runs of raw noise. The closing phase keeps going until
  // a few dozen frames have been checked overall.
  task automatic run_phase(input int n, input bit closing);
    int stop_at;
    stop_at = edges_sent + n;
    while (edges_sent < stop_at || (closing && frames_seen < 48)) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6))
          send_edge(IntervalW'($urandom_range(0, 65535)), 1'b0, '0);
      else
        send_frame();
    end
    drain();
  endtask

  // Directed edges, run with the reset limits.
  //  - no leader since reset: counting starts from zero, every interval sits
  //    on a window limit or outside all windows, so an all-zero frame comes out
  //  - leader just above its lower limit, bits at the inner window limits,
  //    command 0x00 with a matching inverse: check passes
  //  - leader just below its upper limit, all ones: check fails
  edge_row_t script [16] = '{
    '{16'd0,     1,  1'b0, '0},
    '{16'd950,   1,  1'b0, '0},
    '{16'd1120,  1,  1'b0, '0},
    '{16'd1920,  1,  1'b0, '0},
    '{16'd2120,  1,  1'b0, '0},
    '{16'd12200, 1,  1'b0, '0},
    '{16'd13000, 1,  1'b0, '0},
    '{16'd1500,  26, 1'b0, '0},
    '{16'd65535, 1,  1'b1, '{32'h0000_0000, 8'h00, 1'b0}},
    '{16'd12201, 1,  1'b0, '0},
    '{16'd951,   12, 1'b0, '0},
    '{16'd1119,  12, 1'b0, '0},
    '{16'd1921,  4,  1'b0, '0},
    '{16'd2119,  4,  1'b1, '{32'hFF00_0000, 8'h00, 1'b1}},
    '{16'd12999, 1,  1'b0, '0},
    '{16'd2000,  32, 1'b1, '{32'hFFFF_FFFF, 8'hFF, 1'b0}}
  };

  initial begin : stimulus
    cfg_t rand_win;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++)
        send_edge(script[r].interval, script[r].typed && (k == script[r].reps - 1),
                  script[r].want);
    end
    drain();

    // Narrow, separated windows.
    program_windows('{16'd9000, 16'd9500, 16'd500, 16'd700, 16'd1500, 16'd1700});
    run_phase(300, 1'b0);

    // Overlapping windows: leader covers the zero window, one overlaps both.
    program_windows('{16'd900, 16'd1300, 16'd950, 16'd1120, 16'd1000, 16'd2120});
    run_phase(250, 1'b0);

    // Widest windows: almost every interval restarts the frame, so frames
    // never close; kept short.
    program_windows('{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535});
    run_phase(60, 1'b0);

    // Inverted and empty windows: nothing matches, so frames close only by edge count,
    // on a stale shift word. Spare register slots are written too.
    cfg_write(RegSpare6, IntervalW'($urandom_range(0, 65535)));
    cfg_write(RegSpare7, IntervalW'($urandom_range(0, 65535)));
    program_windows('{16'd65535, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd0});
    run_phase(150, 1'b0);

    // Random windows of random width.
    rand_win.leader_low  = IntervalW'($urandom_range(0, 60000));
    rand_win.leader_high = IntervalW'(rand_win.leader_low + $urandom_range(2, 5000));
    rand_win.zero_low    = IntervalW'($urandom_range(0, 60000));
    rand_win.zero_high   = IntervalW'(rand_win.zero_low + $urandom_range(2, 3000));
    rand_win.one_low     = IntervalW'($urandom_range(0, 60000));
    rand_win.one_high    = IntervalW'(rand_win.one_low + $urandom_range(2, 3000));
    program_windows(rand_win);
    run_phase(300, 1'b0);

    // Back to the reset limits, both channels at full rate.
    bursts_on = 1'b0;
    program_windows('{LeaderLowRst, LeaderHighRst, ZeroLowRst, ZeroHighRst,
                      OneLowRst, OneHighRst});
    run_phase(300, 1'b1);

    repeat (8) @(posedge clk_i);
    $display("Covered %0d edge intervals under %0d window settings; %0d frames checked,",
             edges_sent, settings_used, frames_seen);
    $display("%0d field mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("ir_pulse_distance_frame_decoder_top_tb: done, clean");
    end else begin
      $display("ir_pulse_distance_frame_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/irpd_pkg.sv
rtl/core/irpd_cfg_regs.sv
rtl/core/irpd_classify.sv
rtl/core/irpd_frame.sv
rtl/core/ir_pulse_distance_frame_decoder_top.sv
verif/ir_pulse_distance_frame_decoder_top_tb.sv
